// ===== rtl/lgcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgcs_pkg
// shared types, codes and saturation helpers for the gear corrector step unit
// ----------------------------------------------------------------------------
package lgcs_pkg;

  typedef logic signed [47:0] w48_t;
  typedef logic signed [53:0] w54_t;

  typedef enum logic [1:0] {
    KIND_TYPE = 2'd0,
    KIND_INIT = 2'd1,
    KIND_STEP = 2'd2
  } kind_t;

  localparam logic [1:0] CFG_HALF_DT_SQ    = 2'd0;
  localparam logic [1:0] CFG_HALF_GAMMA_DT = 2'd1;
  localparam logic [1:0] CFG_NOISE_GAIN    = 2'd2;
  localparam logic [1:0] CFG_INV_DT        = 2'd3;

  localparam w48_t W48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam w48_t W48_MIN = 48'sh8000_0000_0000;
  localparam w54_t SAT_HI  = 54'sh00_7FFF_FFFF_FFFF;
  localparam w54_t SAT_LO  = 54'sh3F_8000_0000_0000;

  function automatic w54_t x54(input w48_t v);
    return 54'(v);
  endfunction

  function automatic w48_t sat48(input w54_t v);
    if (v > SAT_HI) begin
      return W48_MAX;
    end
    if (v < SAT_LO) begin
      return W48_MIN;
    end
    return 48'(v);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lgcs_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgcs channel interfaces
// step input, result output and register write channels
// ----------------------------------------------------------------------------
interface lgcs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [9:0]         particle;
  logic [4:0]         ptype;
  logic signed [47:0] force_x;
  logic signed [47:0] force_y;
  logic signed [47:0] force_z;
  logic signed [47:0] noise_x;
  logic signed [47:0] noise_y;
  logic signed [47:0] noise_z;
  logic signed [47:0] word_a;
  logic signed [47:0] word_b;
  logic signed [47:0] word_c;
  modport source(output valid, kind, particle, ptype, force_x, force_y, force_z,
                 noise_x, noise_y, noise_z, word_a, word_b, word_c, input ready);
  modport sink(input valid, kind, particle, ptype, force_x, force_y, force_z,
               noise_x, noise_y, noise_z, word_a, word_b, word_c, output ready);
endinterface

interface lgcs_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         particle_out;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic signed [47:0] pos_z;
  logic signed [47:0] vel_x;
  logic signed [47:0] vel_y;
  logic signed [47:0] vel_z;
  modport source(output valid, particle_out, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 input ready);
  modport sink(input valid, particle_out, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               output ready);
endinterface

interface lgcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/lgcs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgcs_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lgcs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lgcs_fmul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgcs_fmul
// three stage fixed point multiplier, round half away, saturate to 48 bits
// ----------------------------------------------------------------------------
module lgcs_fmul
  import lgcs_pkg::*;
#(
  parameter int FRAC_BITS = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [48:0] a,
  input  logic signed [48:0] b,
  output w48_t               p
);

  logic        neg1_r, neg2_r;
  logic [47:0] ma_r, mb_r;
  logic [47:0] hh_r, hl_r, lh_r, ll_r;
  logic [48:0] a_abs, b_abs;
  logic [96:0] sum;
  logic [46:0] mag;
  logic        ovf;
  w48_t        p_nxt;

  assign a_abs = a[48] ? 49'(-a) : 49'(a);
  assign b_abs = b[48] ? 49'(-b) : 49'(b);

  always_comb begin
    sum = (97'(hh_r) << 48) + ((97'(hl_r) + 97'(lh_r)) << 24) + 97'(ll_r)
          + (97'(1) << (FRAC_BITS - 1));
    ovf = (sum >> (FRAC_BITS + 47)) != 97'(0);
    mag = sum[FRAC_BITS+46:FRAC_BITS];
    if (ovf) begin
      p_nxt = neg2_r ? W48_MIN : W48_MAX;
    end else begin
      p_nxt = neg2_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= a[48] ^ b[48];
      ma_r   <= a_abs[47:0];
      mb_r   <= b_abs[47:0];
      neg2_r <= neg1_r;
      hh_r   <= ma_r[47:24] * mb_r[47:24];
      hl_r   <= ma_r[47:24] * mb_r[23:0];
      lh_r   <= ma_r[23:0] * mb_r[47:24];
      ll_r   <= ma_r[23:0] * mb_r[23:0];
      p      <= p_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lgcs_cdiv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lgcs_cdiv
// four stage scale of a signed word by NUM/DEN, rounded half away from zero
// ----------------------------------------------------------------------------
module lgcs_cdiv
  import lgcs_pkg::*;
#(
  parameter int NUM = 1,
  parameter int DEN = 6
) (
  input  logic clk,
  input  logic en,
  input  w48_t e,
  output w48_t q
);

  localparam logic [55:0] RECIP = 56'((64'd1 << 56) / DEN);

  logic         neg1_r, neg2_r, neg3_r;
  logic [55:0]  x1_r, x2_r, x3_r;
  logic [55:0]  hh_r, hl_r, lh_r, ll_r;
  logic [47:0]  q0_r;
  logic [47:0]  mag;
  logic [111:0] sum;
  logic [55:0]  rem;
  logic [47:0]  qc;

  assign mag = e[47] ? 48'(-e) : 48'(e);

  always_comb begin
    sum = (112'(hh_r) << 56) + ((112'(hl_r) + 112'(lh_r)) << 28) + 112'(ll_r);
    rem = x3_r - 56'(q0_r) * 56'(DEN);
    qc  = (rem >= 56'(DEN)) ? q0_r + 48'd1 : q0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= e[47];
      x1_r   <= 56'(mag) * 56'(NUM) + 56'(DEN / 2);
      neg2_r <= neg1_r;
      x2_r   <= x1_r;
      hh_r   <= x1_r[55:28] * RECIP[55:28];
      hl_r   <= x1_r[55:28] * RECIP[27:0];
      lh_r   <= x1_r[27:0] * RECIP[55:28];
      ll_r   <= x1_r[27:0] * RECIP[27:0];
      neg3_r <= neg2_r;
      x3_r   <= x2_r;
      q0_r   <= 48'(sum >> 56);
      q      <= neg3_r ? -$signed(qc) : $signed(qc);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/langevin_gear_corrector_step_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// langevin_gear_corrector_step_unit
// langevin step with fifth order gear predictor-corrector, state in ram
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | word
//  in_ch    | in  | valid/ready  | kind, particle, ptype, force, noise, words
//  out_ch   | out | valid/ready  | particle_out, pos xyz, vel xyz
//  cfg_ch   | in  | valid/ready  | index, data (always ready)
//
//  one word per cycle unless the output stalls or the interlock holds it; a step result leaves from the last stage
//  an init or step word for a particle still in flight waits until that
//  particle is written back (stage 21 of the derivative ram read-modify-write)
//  a stalled result freezes the whole pipeline
//  synchronous reset clears stage valids and config registers only
// ----------------------------------------------------------------------------
module langevin_gear_corrector_step_unit
  import lgcs_pkg::*;
#(
  parameter int PARTICLES = 1024,
  parameter int TYPES     = 32,
  parameter int FRAC_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  lgcs_in_if.sink        in_ch,
  lgcs_out_if.source     out_ch,
  lgcs_cfg_if.sink       cfg_ch
);

  localparam int PW  = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int TW  = (TYPES > 1) ? $clog2(TYPES) : 1;
  localparam int NST = 24;
  localparam int WB  = 21;

  typedef struct {
    logic       step;
    logic       init;
    logic [9:0] particle;
    w48_t       f [3];
    w48_t       nz [3];
    w48_t       mass;
    w48_t       y [6][3];
    w48_t       acc [3];
    w48_t       e [3];
  } stage_t;

  logic [47:0] half_dt_sq_r, half_gamma_dt_r, noise_gain_r, inv_dt_r;

  logic   en, hazard, accept, in_writes, p_ok, t_ok, new_vld, type_we;
  logic   vld_r [1:NST];
  stage_t pipe_r [1:NST];
  stage_t pipe_nxt [1:NST];

  logic [143:0] type_rd;
  logic [863:0] drv_rd, drv_wd;
  w48_t         t_mass, t_inv_mass, t_irm;

  w48_t a_out [3], b_out [3], c_out [3], d_out [3], e_out [3], f_out [3], g_out [3];
  w48_t q3 [3], q251 [3], q11 [3], q6 [3], q60 [3];

  // config registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_dt_sq_r    <= '0;
      half_gamma_dt_r <= '0;
      noise_gain_r    <= '0;
      inv_dt_r        <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_HALF_DT_SQ:    half_dt_sq_r    <= cfg_ch.data;
        CFG_HALF_GAMMA_DT: half_gamma_dt_r <= cfg_ch.data;
        CFG_NOISE_GAIN:    noise_gain_r    <= cfg_ch.data;
        CFG_INV_DT:        inv_dt_r        <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // flow control and same-particle interlock
  assign en = !out_ch.valid || out_ch.ready;

  always_comb begin
    hazard = 1'b0;
    for (int s = 1; s <= WB; s++) begin
      if (vld_r[s] && pipe_r[s].particle == in_ch.particle) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_writes   = (in_ch.kind == KIND_INIT) || (in_ch.kind == KIND_STEP);
  assign in_ch.ready = en && !(hazard && in_writes);
  assign accept      = in_ch.valid && in_ch.ready;
  assign p_ok        = 32'(in_ch.particle) < PARTICLES;
  assign t_ok        = 32'(in_ch.ptype) < TYPES;
  assign new_vld     = accept && p_ok &&
                       ((in_ch.kind == KIND_INIT) || (in_ch.kind == KIND_STEP && t_ok));
  assign type_we     = accept && (in_ch.kind == KIND_TYPE) && t_ok;

  // memories
  lgcs_ram #(.WIDTH(144), .DEPTH(TYPES)) u_type_ram (
    .clk   (clk),
    .we    (type_we),
    .waddr (TW'(in_ch.ptype)),
    .wdata ({in_ch.word_c, in_ch.word_b, in_ch.word_a}),
    .re    (en),
    .raddr (TW'(in_ch.ptype)),
    .rdata (type_rd)
  );

  assign t_mass     = type_rd[47:0];
  assign t_inv_mass = type_rd[95:48];
  assign t_irm      = type_rd[143:96];

  always_comb begin
    for (int d = 0; d < 6; d++) begin
      for (int ax = 0; ax < 3; ax++) begin
        drv_wd[(d*3+ax)*48 +: 48] = pipe_r[WB].y[d][ax];
      end
    end
  end

  lgcs_ram #(.WIDTH(864), .DEPTH(PARTICLES)) u_deriv_ram (
    .clk   (clk),
    .we    (en && vld_r[WB]),
    .waddr (PW'(pipe_r[WB].particle)),
    .wdata (drv_wd),
    .re    (en),
    .raddr (PW'(in_ch.particle)),
    .rdata (drv_rd)
  );

  // arithmetic units, one set per axis
  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    lgcs_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_a (
      .clk(clk), .en(en), .a(49'(pipe_r[1].nz[ax])), .b(49'(t_irm)), .p(a_out[ax]));
    lgcs_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_b (
      .clk(clk), .en(en), .a(49'(pipe_r[1].f[ax])), .b(49'(t_inv_mass)), .p(b_out[ax]));
    lgcs_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_c (
      .clk(clk), .en(en), .a(49'(a_out[ax])), .b({1'b0, noise_gain_r}), .p(c_out[ax]));
    lgcs_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_d (
      .clk(clk), .en(en),
      .a(49'(pipe_r[4].init ? pipe_r[4].f[ax] : b_out[ax])),
      .b({1'b0, half_dt_sq_r}), .p(d_out[ax]));
    lgcs_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_e (
      .clk(clk), .en(en), .a(49'(pipe_r[8].y[1][ax])), .b(49'(pipe_r[8].mass)),
      .p(e_out[ax]));
    lgcs_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_f (
      .clk(clk), .en(en), .a(49'(e_out[ax])), .b({1'b0, half_gamma_dt_r}), .p(f_out[ax]));
    lgcs_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_g (
      .clk(clk), .en(en), .a(49'(pipe_r[WB].y[1][ax])), .b({1'b0, inv_dt_r}),
      .p(g_out[ax]));

    lgcs_cdiv #(.NUM(3),   .DEN(16))  u_div_3   (
      .clk(clk), .en(en), .e(pipe_r[15].e[ax]), .q(q3[ax]));
    lgcs_cdiv #(.NUM(251), .DEN(360)) u_div_251 (
      .clk(clk), .en(en), .e(pipe_r[15].e[ax]), .q(q251[ax]));
    lgcs_cdiv #(.NUM(11),  .DEN(18))  u_div_11  (
      .clk(clk), .en(en), .e(pipe_r[15].e[ax]), .q(q11[ax]));
    lgcs_cdiv #(.NUM(1),   .DEN(6))   u_div_6   (
      .clk(clk), .en(en), .e(pipe_r[15].e[ax]), .q(q6[ax]));
    lgcs_cdiv #(.NUM(1),   .DEN(60))  u_div_60  (
      .clk(clk), .en(en), .e(pipe_r[15].e[ax]), .q(q60[ax]));
  end

  // pipeline next state
  always_comb begin
    w48_t c [6];

    pipe_nxt[1].step     = in_ch.kind == KIND_STEP;
    pipe_nxt[1].init     = in_ch.kind == KIND_INIT;
    pipe_nxt[1].particle = in_ch.particle;
    pipe_nxt[1].f        = '{in_ch.force_x, in_ch.force_y, in_ch.force_z};
    pipe_nxt[1].nz       = '{in_ch.noise_x, in_ch.noise_y, in_ch.noise_z};
    pipe_nxt[1].mass     = '0;
    pipe_nxt[1].acc      = '{'0, '0, '0};
    pipe_nxt[1].e        = '{'0, '0, '0};
    pipe_nxt[1].y[0]     = '{in_ch.word_a, in_ch.word_b, in_ch.word_c};
    pipe_nxt[1].y[1]     = '{in_ch.noise_x, in_ch.noise_y, in_ch.noise_z};
    for (int d = 2; d < 6; d++) begin
      pipe_nxt[1].y[d] = '{'0, '0, '0};
    end

    for (int s = 2; s <= NST; s++) begin
      pipe_nxt[s] = pipe_r[s-1];
    end

    // ram data for a step
    if (pipe_r[1].step) begin
      pipe_nxt[2].mass = t_mass;
      for (int d = 0; d < 6; d++) begin
        for (int ax = 0; ax < 3; ax++) begin
          pipe_nxt[2].y[d][ax] = drv_rd[(d*3+ax)*48 +: 48];
        end
      end
    end

    for (int ax = 0; ax < 3; ax++) begin
      // noise kick and acceleration, or initial y2
      if (pipe_r[7].step) begin
        pipe_nxt[8].y[1][ax] = sat48(x54(pipe_r[7].y[1][ax]) + x54(c_out[ax]));
        pipe_nxt[8].acc[ax]  = d_out[ax];
      end else begin
        pipe_nxt[8].y[2][ax] = d_out[ax];
      end

      // corrector error
      pipe_nxt[15].e[ax] = sat48(x54(pipe_r[14].y[2][ax]) - x54(pipe_r[14].acc[ax])
                                 + x54(f_out[ax]));

      // corrector
      if (pipe_r[19].step) begin
        pipe_nxt[20].y[0][ax] = sat48(x54(pipe_r[19].y[0][ax]) - x54(q3[ax]));
        pipe_nxt[20].y[1][ax] = sat48(x54(pipe_r[19].y[1][ax]) - x54(q251[ax]));
        pipe_nxt[20].y[2][ax] = sat48(x54(pipe_r[19].y[2][ax]) - x54(pipe_r[19].e[ax]));
        pipe_nxt[20].y[3][ax] = sat48(x54(pipe_r[19].y[3][ax]) - x54(q11[ax]));
        pipe_nxt[20].y[4][ax] = sat48(x54(pipe_r[19].y[4][ax]) - x54(q6[ax]));
        pipe_nxt[20].y[5][ax] = sat48(x54(pipe_r[19].y[5][ax]) - x54(q60[ax]));
      end

      // predictor
      for (int d = 0; d < 6; d++) begin
        c[d] = pipe_r[20].y[d][ax];
      end
      if (pipe_r[20].step) begin
        pipe_nxt[21].y[0][ax] = sat48(x54(c[0]) + x54(c[1]) + x54(c[2]) + x54(c[3])
                                      + x54(c[4]) + x54(c[5]));
        pipe_nxt[21].y[1][ax] = sat48(x54(c[1]) + 2 * x54(c[2]) + 3 * x54(c[3])
                                      + 4 * x54(c[4]) + 5 * x54(c[5]));
        pipe_nxt[21].y[2][ax] = sat48(x54(c[2]) + 3 * x54(c[3]) + 6 * x54(c[4])
                                      + 10 * x54(c[5]));
        pipe_nxt[21].y[3][ax] = sat48(x54(c[3]) + 4 * x54(c[4]) + 10 * x54(c[5]));
        pipe_nxt[21].y[4][ax] = sat48(x54(c[4]) + 5 * x54(c[5]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NST; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (en) begin
      vld_r[1] <= new_vld;
      for (int s = 2; s <= NST; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 1; s <= NST; s++) begin
        pipe_r[s] <= pipe_nxt[s];
      end
    end
  end

  // result word
  assign out_ch.valid        = vld_r[NST] && pipe_r[NST].step;
  assign out_ch.particle_out = pipe_r[NST].particle;
  assign out_ch.pos_x        = pipe_r[NST].y[0][0];
  assign out_ch.pos_y        = pipe_r[NST].y[0][1];
  assign out_ch.pos_z        = pipe_r[NST].y[0][2];
  assign out_ch.vel_x        = g_out[0];
  assign out_ch.vel_y        = g_out[1];
  assign out_ch.vel_z        = g_out[2];

endmodule
`default_nettype wire
